// File: src/tmm_pkg.sv
// Shared types and constants for the clock domain tag min/max table.
`default_nettype none
package tmm_pkg;

  localparam int unsigned DomInW   = 8;
  localparam int unsigned TimeIoW  = 32;
  localparam int unsigned LaunchW  = 24;
  localparam int unsigned TotalW   = 4;

  typedef enum logic [1:0] {
    KIND_MAX_ARR = 2'd0,
    KIND_MIN_REQ = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_UPDATE = 2'd2
  } state_e;

  typedef struct packed {
    kind_e                      kind;
    logic [DomInW-1:0]          domain;
    logic signed [TimeIoW-1:0]  time_value;
    logic                       time_valid;
    logic [LaunchW-1:0]         launch_src;
  } req_t;

  typedef struct packed {
    logic                       found;
    logic                       created;
    logic                       dropped;
    logic                       overflow;
    logic signed [TimeIoW-1:0]  arrival_out;
    logic                       arrival_ok;
    logic signed [TimeIoW-1:0]  required_out;
    logic                       required_ok;
    logic [LaunchW-1:0]         launch_out;
    logic [TotalW-1:0]          entry_total;
  } res_t;

endpackage
`default_nettype wire

// File: src/clock_domain_tag_minmax_table.sv
// Top level: clock domain timing tag table with sequential search and merge.
//
// Usage: drive req_i and raise start; the request is taken at a rising edge
// where start is high and busy is low. Each request gives exactly one result
// on res_o, marked by res_valid_o for one cycle; the receiver must take it.
// Clear requests, unused kinds and updates for the reserved domain finish at
// once: the result shows in the next cycle and busy stays low, so such
// requests can be issued every cycle.
// Updates walk the table through the RAM read port, one entry per cycle
// (the read is registered, so each match is checked on the registered read
// data), then compare and write in the merge unit in the update state.
// Busy stays high through the scan and update states; the result appears in
// the same cycle busy falls, and a new request can enter in the cycle the
// result is shown. Reset empties the table (entry count zero) and returns to
// idle; entry RAM contents need no clearing since only entries below the
// count are used.
`default_nettype none
module clock_domain_tag_minmax_table #(
  parameter int unsigned MAX_TAGS    = 8,
  parameter int unsigned DOMAIN_BITS = 8,
  parameter int unsigned TIME_BITS   = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire tmm_pkg::req_t req_i,
  output logic               res_valid_o,
  output tmm_pkg::res_t      res_o
);
  import tmm_pkg::*;

  localparam int unsigned CW = $clog2(MAX_TAGS + 1);
  localparam int unsigned AW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam int unsigned EW = DOMAIN_BITS + 2 * TIME_BITS + 2 + LaunchW;

  localparam int unsigned OffRqOk  = LaunchW;
  localparam int unsigned OffRq    = LaunchW + 1;
  localparam int unsigned OffArrOk = LaunchW + 1 + TIME_BITS;
  localparam int unsigned OffArr   = LaunchW + 2 + TIME_BITS;
  localparam int unsigned OffDom   = LaunchW + 2 + 2 * TIME_BITS;

  state_e state_q, state_d;

  logic [CW-1:0]          count_q;
  logic [CW-1:0]          scan_idx_q;
  logic                   pend_q;
  logic [AW-1:0]          pend_idx_q;
  logic                   hit_q;
  logic [AW-1:0]          hit_idx_q;
  logic [EW-1:0]          entry_q;
  kind_e                  kind_q;
  logic [DOMAIN_BITS-1:0] dom_q;
  logic [TIME_BITS-1:0]   t_q;
  logic                   tv_q;
  logic [LaunchW-1:0]     launch_q;
  logic                   res_valid_q;
  res_t                   res_q;

  logic [DOMAIN_BITS-1:0] dom_in;
  logic [63:0]            time_in64;
  logic [TIME_BITS-1:0]   t_in;
  logic                   reserved;
  logic                   is_update;
  logic                   quick;
  logic                   accept;
  logic                   issue;
  logic                   match;
  logic                   full;
  logic                   create;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic [EW-1:0]          ram_rdata;
  logic [CW-1:0]          count_upd;
  res_t                   res_quick;
  res_t                   res_upd;

  logic [TIME_BITS-1:0]   new_arr;
  logic                   new_arr_ok;
  logic [TIME_BITS-1:0]   new_rq;
  logic                   new_rq_ok;
  logic [LaunchW-1:0]     new_launch;
  logic [63:0]            arr_ext;
  logic [63:0]            rq_ext;

  assign dom_in    = DOMAIN_BITS'(req_i.domain);
  assign time_in64 = 64'($unsigned(req_i.time_value));
  assign t_in      = req_i.time_valid ? time_in64[TIME_BITS-1:0] : '0;
  assign reserved  = (dom_in == '1);
  assign is_update = (req_i.kind == KIND_MAX_ARR) || (req_i.kind == KIND_MIN_REQ);
  assign quick     = !is_update || reserved;
  assign accept    = start && !busy;

  assign match     = pend_q && (ram_rdata[OffDom +: DOMAIN_BITS] == dom_q);
  assign full      = (count_q >= CW'(MAX_TAGS));
  assign create    = !hit_q && !full;
  assign count_upd = count_q + CW'(create);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start && !quick) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match || !issue) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy   = 1'b1;
    issue  = 1'b0;
    ram_we = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_SCAN: begin
        issue = (scan_idx_q < count_q);
      end
      ST_UPDATE: begin
        ram_we = hit_q || !full;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  tmm_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TAGS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  tmm_merge #(
    .TIME_BITS (TIME_BITS)
  ) u_merge (
    .kind_i       (kind_q),
    .found_i      (hit_q),
    .t_i          (t_q),
    .tv_i         (tv_q),
    .launch_i     (launch_q),
    .arr_i        (entry_q[OffArr +: TIME_BITS]),
    .arr_ok_i     (entry_q[OffArrOk]),
    .rq_i         (entry_q[OffRq +: TIME_BITS]),
    .rq_ok_i      (entry_q[OffRqOk]),
    .launch_old_i (entry_q[LaunchW-1:0]),
    .arr_o        (new_arr),
    .arr_ok_o     (new_arr_ok),
    .rq_o         (new_rq),
    .rq_ok_o      (new_rq_ok),
    .launch_o     (new_launch)
  );

  assign ram_waddr = hit_q ? hit_idx_q : count_q[AW-1:0];
  assign ram_wdata = {dom_q, new_arr, new_arr_ok, new_rq, new_rq_ok, new_launch};
  assign arr_ext   = 64'($signed(new_arr));
  assign rq_ext    = 64'($signed(new_rq));

  always_comb begin
    res_upd             = '0;
    res_upd.found       = hit_q;
    res_upd.created     = create;
    res_upd.dropped     = !hit_q && full;
    res_upd.overflow    = !hit_q && full;
    res_upd.entry_total = TotalW'(count_upd);
    if (hit_q || create) begin
      res_upd.arrival_out  = arr_ext[TimeIoW-1:0];
      res_upd.arrival_ok   = new_arr_ok;
      res_upd.required_out = rq_ext[TimeIoW-1:0];
      res_upd.required_ok  = new_rq_ok;
      res_upd.launch_out   = new_launch;
    end
  end

  always_comb begin
    res_quick         = '0;
    res_quick.dropped = is_update && reserved;
    res_quick.entry_total = (req_i.kind == KIND_CLEAR) ? '0 : TotalW'(count_q);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_idx_q  <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (accept && quick) || (state_q == ST_UPDATE);
      if (accept) begin
        scan_idx_q <= '0;
        pend_q     <= 1'b0;
        if (quick && (req_i.kind == KIND_CLEAR)) begin
          count_q <= '0;
        end
      end
      if (state_q == ST_SCAN) begin
        scan_idx_q <= scan_idx_q + CW'(issue);
        pend_q     <= issue;
        if (match) begin
          hit_q <= 1'b1;
        end else if (!issue) begin
          hit_q <= 1'b0;
        end
      end
      if (state_q == ST_UPDATE) begin
        count_q <= count_upd;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= req_i.kind;
      dom_q    <= dom_in;
      t_q      <= t_in;
      tv_q     <= req_i.time_valid;
      launch_q <= req_i.launch_src;
      res_q    <= res_quick;
    end
    if (state_q == ST_SCAN) begin
      pend_idx_q <= scan_idx_q[AW-1:0];
      if (match) begin
        hit_idx_q <= pend_idx_q;
        entry_q   <= ram_rdata;
      end
    end
    if (state_q == ST_UPDATE) begin
      res_q <= res_upd;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_TAGS))
    else $error("entry count above table size");

  a_found_xor_created: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(res_q.found && res_q.created))
    else $error("result both found and created");

  a_ovf_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.overflow) |-> res_q.dropped)
    else $error("overflow without drop");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.kind == KIND_CLEAR) |=> (res_valid_q && count_q == '0))
    else $error("clear did not empty the table");

  a_update_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |=> (res_valid_q && !busy))
    else $error("update finished without a result");

endmodule
`default_nettype wire

// File: src/tmm_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module tmm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: src/tmm_merge.sv
// Compare-and-merge unit: one signed comparator decides the max/min tag update.
`default_nettype none
module tmm_merge #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire tmm_pkg::kind_e          kind_i,
  input  wire logic                    found_i,
  input  wire logic [TIME_BITS-1:0]    t_i,
  input  wire logic                    tv_i,
  input  wire logic [tmm_pkg::LaunchW-1:0] launch_i,
  input  wire logic [TIME_BITS-1:0]    arr_i,
  input  wire logic                    arr_ok_i,
  input  wire logic [TIME_BITS-1:0]    rq_i,
  input  wire logic                    rq_ok_i,
  input  wire logic [tmm_pkg::LaunchW-1:0] launch_old_i,
  output logic      [TIME_BITS-1:0]    arr_o,
  output logic                         arr_ok_o,
  output logic      [TIME_BITS-1:0]    rq_o,
  output logic                         rq_ok_o,
  output logic      [tmm_pkg::LaunchW-1:0] launch_o
);
  import tmm_pkg::*;

  logic                 is_max;
  logic [TIME_BITS-1:0] op_a;
  logic [TIME_BITS-1:0] op_b;
  logic                 lt;
  logic                 upd;

  assign is_max = (kind_i == KIND_MAX_ARR);
  // max: stored < new ; min: new < stored
  assign op_a   = is_max ? arr_i : t_i;
  assign op_b   = is_max ? t_i : rq_i;
  assign lt     = $signed(op_a) < $signed(op_b);
  assign upd    = is_max ? (!arr_ok_i || (tv_i && lt)) : (!rq_ok_i || (tv_i && lt));

  always_comb begin
    if (found_i) begin
      arr_o    = arr_i;
      arr_ok_o = arr_ok_i;
      rq_o     = rq_i;
      rq_ok_o  = rq_ok_i;
      launch_o = launch_old_i;
      if (upd) begin
        if (is_max) begin
          arr_o    = t_i;
          arr_ok_o = tv_i;
          launch_o = launch_i;
        end else begin
          rq_o    = t_i;
          rq_ok_o = tv_i;
        end
      end
    end else begin
      launch_o = launch_i;
      if (is_max) begin
        arr_o    = t_i;
        arr_ok_o = tv_i;
        rq_o     = '0;
        rq_ok_o  = 1'b0;
      end else begin
        arr_o    = '0;
        arr_ok_o = 1'b0;
        rq_o     = t_i;
        rq_ok_o  = tv_i;
      end
    end
  end

endmodule
`default_nettype wire
